/* hw/rtl/interval_set_coverage_unit_defines.svh */
// Assertion macros shared by the interval set coverage checker.
`ifndef INTERVAL_SET_COVERAGE_UNIT_DEFINES_SVH
`define INTERVAL_SET_COVERAGE_UNIT_DEFINES_SVH

// Same-cycle implication.
`define ISC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ISC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/isc_pkg.sv */
// Types and constants of the interval set coverage unit.
`default_nettype none
package isc_pkg;
	localparam int ID_W   = 63;
	localparam int MARK_W = ID_W + 1;
	localparam int CNT_W  = 32;

	typedef logic [ID_W-1:0]   id_t;
	typedef logic [MARK_W-1:0] mark_t;
	typedef logic [1:0]        status_t;

	localparam status_t STAT_OK    = 2'd0;
	localparam status_t STAT_FULL  = 2'd1;
	localparam status_t STAT_ORDER = 2'd2;

	localparam logic FUNC_ADD   = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	// Result of the shared subtract/compare unit.
	typedef struct packed {
		logic  lt;
		mark_t diff;
	} alu_res_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_INS_START,
		ST_INS_RUN,
		ST_INS_ZERO,
		ST_SW_START,
		ST_SW_RUN,
		ST_SW_DRAIN,
		ST_Q_START,
		ST_Q_RUN,
		ST_FIN
	} isc_state_t;
endpackage
`default_nettype wire

/* hw/rtl/isc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module isc_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 512
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

/* hw/rtl/isc_alu.sv */
// Shared 64-bit subtractor; the borrow doubles as the less-than compare.
`default_nettype none
module isc_alu (
	input  wire isc_pkg::mark_t    a,
	input  wire isc_pkg::mark_t    b,
	output isc_pkg::alu_res_t      res
);
	import isc_pkg::*;

	logic [MARK_W:0] wide;

	assign wide     = {1'b0, a} - {1'b0, b};
	assign res.lt   = wide[MARK_W];
	assign res.diff = wide[MARK_W-1:0];
endmodule
`default_nettype wire

/* hw/rtl/interval_set_coverage_unit.sv */
// Top level: closed interval store with union size and point membership.
`default_nettype none
// Keeps up to MAX_RANGES closed ID ranges as sorted begin/end marks in one RAM of
// 2*MAX_RANGES words and works on one transaction at a time; req_stall is high
// from acceptance until the result is registered. Everything runs through the
// single RAM port pair and one shared 64-bit subtractor, one mark per cycle. A
// query scans the marks from the bottom and stops at the first mark that does not
// sort below the key, or at the last mark. An add runs the insertion shifts for
// the begin and the end mark and then the union sweep over the RAM. A rejected
// add goes from the check straight to the result. A stalled result keeps the
// block busy. The store needs no clearing after reset.
module interval_set_coverage_unit #(
	parameter int MAX_RANGES = 256
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	output logic                 req_stall,
	input  wire logic            func,
	input  wire isc_pkg::id_t    range_begin,
	input  wire isc_pkg::id_t    range_end,
	input  wire isc_pkg::id_t    point_id,
	output logic                 rsp_valid,
	input  wire logic            rsp_stall,
	output isc_pkg::status_t     status,
	output logic                 covered,
	output logic [31:0]          inside_count,
	output logic [63:0]          union_size
);
	import isc_pkg::*;

	localparam int DEPTH = 2 * MAX_RANGES;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int DW    = $clog2(MAX_RANGES + 1);

	isc_state_t        state_q, state_d;
	logic [CW-1:0]     count_q;
	logic [AW-1:0]     cur_q;
	logic              ins_end_q;
	logic              func_q;
	id_t               beg_q, end_q, pt_q;
	status_t           st_q;
	logic [DW-1:0]     depth_q, net_q;
	id_t               open_q;
	mark_t             len_q;
	logic              add_q;
	logic [63:0]       union_q;
	logic [CNT_W-1:0]  inside_q;
	logic              rsp_valid_q;
	status_t           status_q;
	logic              covered_q;
	logic [CNT_W-1:0]  inside_count_q;
	logic [63:0]       union_size_q;

	logic              we;
	logic [AW-1:0]     waddr, raddr;
	mark_t             wdata, rdata;
	mark_t             alu_a, alu_b;
	alu_res_t          alu_res;

	logic [CW-1:0]     cnt_m1;
	logic [AW-1:0]     last_a, cur_nxt, cur_prv;
	mark_t             ins_mark;
	logic              ins_done, chk_order, chk_full, rsp_load, hit, bump;

	assign cnt_m1   = count_q - CW'(1);
	assign last_a   = cnt_m1[AW-1:0];
	assign cur_nxt  = cur_q + AW'(1);
	assign cur_prv  = cur_q - AW'(1);
	assign ins_mark = ins_end_q ? {end_q, 1'b1} : {beg_q, 1'b0};
	assign hit      = (func_q == FUNC_QUERY) && (net_q != '0);
	assign bump     = rsp_load && hit && (inside_q != '1);

	isc_ram #(.WIDTH(MARK_W), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	isc_alu u_alu (
		.a   (alu_a),
		.b   (alu_b),
		.res (alu_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		we        = 1'b0;
		waddr     = cur_nxt;
		wdata     = rdata;
		raddr     = cur_q;
		alu_a     = ins_mark;
		alu_b     = rdata;
		ins_done  = 1'b0;
		chk_order = 1'b0;
		chk_full  = 1'b0;
		rsp_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_d = (func == FUNC_QUERY) ? ST_Q_START : ST_CHECK;
				end
			end
			ST_CHECK: begin
				alu_a     = {1'b0, end_q};
				alu_b     = {1'b0, beg_q};
				chk_order = alu_res.lt;
				chk_full  = count_q > CW'(DEPTH - 2);
				state_d   = (chk_order || chk_full) ? ST_FIN : ST_INS_START;
			end
			ST_INS_START: begin
				if (count_q == '0) begin
					we       = 1'b1;
					waddr    = '0;
					wdata    = ins_mark;
					ins_done = 1'b1;
				end else begin
					raddr   = last_a;
					state_d = ST_INS_RUN;
				end
			end
			ST_INS_RUN: begin
				// rdata holds entry cur_q; shift it up while it sorts above the mark
				we = 1'b1;
				if (alu_res.lt) begin
					wdata = rdata;
					if (cur_q == '0) begin
						state_d = ST_INS_ZERO;
					end else begin
						raddr = cur_prv;
					end
				end else begin
					wdata    = ins_mark;
					ins_done = 1'b1;
				end
			end
			ST_INS_ZERO: begin
				we       = 1'b1;
				waddr    = '0;
				wdata    = ins_mark;
				ins_done = 1'b1;
			end
			ST_SW_START: begin
				raddr   = '0;
				state_d = ST_SW_RUN;
			end
			ST_SW_RUN: begin
				raddr = cur_nxt;
				alu_a = {1'b0, rdata[MARK_W-1:1]};
				alu_b = {1'b0, open_q};
				if (cur_q == last_a) begin
					state_d = ST_SW_DRAIN;
				end
			end
			ST_SW_DRAIN: begin
				state_d = ST_FIN;
			end
			ST_Q_START: begin
				raddr   = '0;
				state_d = (count_q == '0) ? ST_FIN : ST_Q_RUN;
			end
			ST_Q_RUN: begin
				// key sorts above begins at or below the ID and ends below it
				raddr = cur_nxt;
				alu_a = rdata;
				alu_b = {pt_q, 1'b1};
				if (!alu_res.lt || cur_q == last_a) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (!rsp_valid_q || !rsp_stall) begin
					rsp_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (ins_done) begin
			state_d = ins_end_q ? ST_SW_START : ST_INS_START;
		end
	end

	// control and architectural totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			union_q     <= '0;
			inside_q    <= '0;
			rsp_valid_q <= 1'b0;
			add_q       <= 1'b0;
		end else begin
			if (ins_done) begin
				count_q <= count_q + CW'(1);
			end
			// an end mark closing the outermost range adds its length next cycle
			add_q <= (state_q == ST_SW_RUN) && rdata[0] && (depth_q == DW'(1));
			if (state_q == ST_SW_START) begin
				union_q <= '0;
			end else if (add_q) begin
				union_q <= union_q + len_q + 64'(1);
			end
			if (bump) begin
				inside_q <= inside_q + CNT_W'(1);
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// working registers and result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req_valid) begin
			func_q <= func;
			beg_q  <= range_begin;
			end_q  <= range_end;
			pt_q   <= point_id;
			st_q   <= STAT_OK;
		end
		if (state_q == ST_CHECK) begin
			ins_end_q <= 1'b0;
			if (chk_order) begin
				st_q <= STAT_ORDER;
			end else if (chk_full) begin
				st_q <= STAT_FULL;
			end
		end
		if (ins_done) begin
			ins_end_q <= 1'b1;
		end
		unique case (state_q)
			ST_INS_START: cur_q <= last_a;
			ST_INS_RUN: begin
				if (alu_res.lt && cur_q != '0) begin
					cur_q <= cur_prv;
				end
			end
			ST_SW_START: begin
				cur_q   <= '0;
				depth_q <= '0;
			end
			ST_SW_RUN: begin
				cur_q <= cur_nxt;
				if (!rdata[0]) begin
					if (depth_q == '0) begin
						open_q <= rdata[MARK_W-1:1];
					end
					depth_q <= depth_q + DW'(1);
				end else if (depth_q != '0) begin
					depth_q <= depth_q - DW'(1);
					if (depth_q == DW'(1)) begin
						len_q <= alu_res.diff;
					end
				end
			end
			ST_Q_START: begin
				cur_q <= '0;
				net_q <= '0;
			end
			ST_Q_RUN: begin
				cur_q <= cur_nxt;
				if (alu_res.lt) begin
					net_q <= rdata[0] ? net_q - DW'(1) : net_q + DW'(1);
				end
			end
			default: begin
			end
		endcase
		if (rsp_load) begin
			status_q       <= st_q;
			covered_q      <= hit;
			inside_count_q <= bump ? inside_q + CNT_W'(1) : inside_q;
			union_size_q   <= union_q;
		end
	end

	assign req_stall    = (state_q != ST_IDLE);
	assign rsp_valid    = rsp_valid_q;
	assign status       = status_q;
	assign covered      = covered_q;
	assign inside_count = inside_count_q;
	assign union_size   = union_size_q;
endmodule
`default_nettype wire

/* hw/rtl/isc_checker.sv */
// Port-level checker for the interval set coverage unit, bound to the top level.
`default_nettype none
`include "interval_set_coverage_unit_defines.svh"
module isc_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              req_valid,
	input wire logic              req_stall,
	input wire logic              func,
	input wire isc_pkg::id_t      range_begin,
	input wire isc_pkg::id_t      range_end,
	input wire isc_pkg::id_t      point_id,
	input wire logic              rsp_valid,
	input wire logic              rsp_stall,
	input wire isc_pkg::status_t  status,
	input wire logic              covered,
	input wire logic [31:0]       inside_count,
	input wire logic [63:0]       union_size
);
	import isc_pkg::*;

	`ISC_ASSERT_NEXT(a_req_hold, clk, arst_n, req_valid && req_stall, req_valid && $stable(func) && $stable(range_begin) && $stable(range_end) && $stable(point_id), "stalled request changed")
	`ISC_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall, rsp_valid && $stable(status) && $stable(covered) && $stable(inside_count) && $stable(union_size), "stalled result changed")
	`ISC_ASSERT_NEXT(a_busy_after_req, clk, arst_n, req_valid && !req_stall, req_stall, "block not busy after a transaction was taken")
	`ISC_ASSERT_NOW(a_status_code, clk, arst_n, rsp_valid, status == STAT_OK || status == STAT_FULL || status == STAT_ORDER, "bad status code")
	`ISC_ASSERT_NOW(a_hit_ok, clk, arst_n, rsp_valid && covered, status == STAT_OK && inside_count != 32'd0, "covered result with bad status or count")
endmodule

bind interval_set_coverage_unit isc_checker u_isc_checker (.*);
`default_nettype wire
